@@ rtl/smbp_pkg.sv @@
package smbp_pkg;

	// Default width of byte offsets inside one structure.
	localparam int unsigned OFFSET_WIDTH_DEF = 16;

	// Header layout and limits.
	localparam logic [7:0] END_OF_TABLE_TYPE = 8'd127;
	localparam logic [7:0] HEADER_BYTES      = 8'd4;
	localparam logic [7:0] STRING_SET_MIN    = 8'd2;

	// Record kinds.
	localparam logic [1:0] KIND_STRING = 2'd0;
	localparam logic [1:0] KIND_DONE   = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// Error codes.
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_TRUNCATED  = 2'd1;
	localparam logic [1:0] ERR_BAD_LENGTH = 2'd2;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'b0001,
		PH_HEADER    = 4'b0010,
		PH_FORMATTED = 4'b0100,
		PH_STRINGS   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        start_flag;
		logic [15:0] bytes_available;
	} item_t;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic [1:0]  error_code;
		logic [7:0]  struct_type;
		logic [15:0] struct_handle;
		logic [7:0]  formatted_length;
		logic [15:0] struct_size;
		logic [15:0] string_tally;
		logic [15:0] string_number;
		logic [15:0] trim_offset;
		logic [15:0] trim_length;
	} result_t;

	// Whitespace for trimming: tab, line feed, vertical tab, form feed,
	// carriage return and space.
	function automatic logic is_blank(input logic [7:0] b);
		return ((b >= 8'd9) && (b <= 8'd13)) || (b == 8'd32);
	endfunction

endpackage

@@ rtl/smbios_structure_parser.sv @@
// Data path: a transferred byte is held in the input register and parsed from there;
// any record it causes goes through the result register onto the result port.
// Throughput: one byte per cycle while the result side keeps up; a record held
// downstream stops the parse stage until it is transferred.
// Reset: arst_n is asynchronous and active low; it empties both the input register and
// the result register and returns the parser to idle, waiting for a start byte.
module smbios_structure_parser #(
	parameter int unsigned OFFSET_WIDTH = smbp_pkg::OFFSET_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  smbp_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output smbp_pkg::result_t result
);
	import smbp_pkg::*;

	// Input register. A byte waits here until the parse stage can run, which
	// it can whenever the result register is empty or is being drained in the
	// same cycle. While a finished record waits for its transfer downstream,
	// the parse stage stops and the input side takes at most one more byte,
	// which then waits here.
	logic    item_valid_s1;
	item_t   item_s1;

	// Result register, which decouples the parse stage from the consumer.
	logic    result_valid_q;
	result_t result_q;

	logic    step_en;
	logic    res_valid;
	result_t res;

	assign step_en    = item_valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !item_valid_s1 || step_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_ready) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// The parse stage: header capture, length checks, the walk over the
	// formatted area and the string set scan with whitespace trimming.
	smbp_core #(
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (step_en),
		.item     (item_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	// A transfer downstream empties the register; a new record fills it in
	// the same cycle if the parse stage produced one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (step_en && res_valid) begin
				result_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && res_valid) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// Only error records carry an error code.
	a_err_matches_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result.record_kind == KIND_ERROR) == (result.error_code != ERR_NONE)))
		else $error("error code does not match record kind");

	// A string record numbers itself and its running count alike, never zero.
	a_string_number: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.record_kind == KIND_STRING) |->
		(result.string_number == result.string_tally) && (result.string_number != 16'd0))
		else $error("string record numbering broken");

	// A record that is not taken must not be replaced by the parse stage.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !step_en)
		else $error("parse stage ran while the result register was held");

	// A held byte stays in the input register until it is parsed.
	a_input_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid_s1 && !step_en |=> item_valid_s1 && $stable(item_s1))
		else $error("input register lost a byte");
`endif

endmodule

@@ rtl/smbp_core.sv @@
module smbp_core #(
	parameter int unsigned OFFSET_WIDTH = smbp_pkg::OFFSET_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  smbp_pkg::item_t  item,
	output logic             res_valid,
	output smbp_pkg::result_t res
);
	import smbp_pkg::*;

	localparam int unsigned W  = OFFSET_WIDTH;
	localparam int unsigned CW = OFFSET_WIDTH + 2;

	phase_t       phase_q;
	logic [W-1:0] pos_q;
	logic [W-1:0] limit_q;
	logic [7:0]   htype_q;
	logic [7:0]   hlen_q;
	logic [15:0]  handle_q;
	logic         present_q;
	logic         prev_nul_q;
	logic [W-1:0] seen_q;
	logic [W-1:0] first_q;
	logic [W-1:0] last_q;
	logic         nsseen_q;

	phase_t       phase_d;
	logic [W-1:0] pos_d;
	logic [W-1:0] limit_d;
	logic [7:0]   htype_d;
	logic [7:0]   hlen_d;
	logic [15:0]  handle_d;
	logic         present_d;
	logic         prev_nul_d;
	logic [W-1:0] seen_d;
	logic [W-1:0] first_d;
	logic [W-1:0] last_d;
	logic         nsseen_d;

	// State as seen by this byte, after a start has cleared it.
	phase_t       ph;
	logic [W-1:0] pos;
	logic [W-1:0] lim;
	logic [7:0]   htype;
	logic [7:0]   hlen;
	logic [15:0]  handle;
	logic         present;
	logic         prev_nul;
	logic [W-1:0] seen;
	logic [W-1:0] first;
	logic [W-1:0] last;
	logic         nsseen;

	logic [7:0]    b;
	logic          nul;
	logic          ns_cur;
	logic [7:0]    eff_len;
	logic [CW-1:0] pos_x;
	logic [CW-1:0] pos_inc_x;
	logic [CW-1:0] lim_x;
	logic [CW-1:0] hlen_x;
	logic [W:0]    tlen_w;
	logic [W-1:0]  seen_inc;
	logic [1:0]    kind;
	logic [1:0]    err;
	logic [15:0]   total;
	logic [15:0]   count;
	logic [15:0]   num;
	logic [15:0]   toff;
	logic [15:0]   tlen;

	always_comb begin
		b        = item.data_byte;
		nul      = (b == 8'd0);
		ph       = item.start_flag ? PH_HEADER : phase_q;
		pos      = item.start_flag ? '0 : pos_q;
		lim      = item.start_flag ? W'(item.bytes_available) : limit_q;
		htype    = item.start_flag ? 8'd0 : htype_q;
		hlen     = item.start_flag ? 8'd0 : hlen_q;
		handle   = item.start_flag ? 16'd0 : handle_q;
		present  = item.start_flag ? 1'b0 : present_q;
		prev_nul = item.start_flag ? 1'b0 : prev_nul_q;
		seen     = item.start_flag ? '0 : seen_q;
		first    = item.start_flag ? '0 : first_q;
		last     = item.start_flag ? '0 : last_q;
		nsseen   = item.start_flag ? 1'b0 : nsseen_q;

		pos_x     = CW'(pos);
		pos_inc_x = pos_x + CW'(1);
		lim_x     = CW'(lim);
		hlen_x    = CW'(hlen);
		seen_inc  = seen + W'(1);
		eff_len   = (hlen == 8'd0) ? HEADER_BYTES : hlen;
		ns_cur    = nsseen;
		tlen_w    = '0;

		phase_d    = ph;
		pos_d      = pos + W'(1);
		limit_d    = lim;
		htype_d    = htype;
		hlen_d     = hlen;
		handle_d   = handle;
		present_d  = present;
		prev_nul_d = prev_nul;
		seen_d     = seen;
		first_d    = first;
		last_d     = last;
		nsseen_d   = nsseen;

		res_valid = 1'b0;
		kind      = KIND_ERROR;
		err       = ERR_NONE;
		total     = 16'd0;
		count     = 16'd0;
		num       = 16'd0;
		toff      = 16'd0;
		tlen      = 16'd0;

		case (ph)
			PH_IDLE: begin
				pos_d = pos;
			end
			PH_HEADER: begin
				if (pos == W'(0)) begin
					htype_d = b;
					if (lim_x < CW'(HEADER_BYTES + STRING_SET_MIN)) begin
						res_valid = 1'b1;
						err       = ERR_TRUNCATED;
						phase_d   = PH_IDLE;
					end
				end else if (pos == W'(1)) begin
					hlen_d = b;
				end else if (pos == W'(2)) begin
					handle_d = {8'd0, b};
				end else begin
					handle_d = {b, handle[7:0]};
					hlen_d   = eff_len;
					if (hlen == 8'd0) begin
						htype_d = END_OF_TABLE_TYPE;
					end
					if (eff_len < HEADER_BYTES) begin
						res_valid = 1'b1;
						err       = ERR_BAD_LENGTH;
						phase_d   = PH_IDLE;
					end else if (CW'(eff_len) + CW'(STRING_SET_MIN) > lim_x) begin
						res_valid = 1'b1;
						err       = ERR_TRUNCATED;
						phase_d   = PH_IDLE;
					end else begin
						phase_d = (eff_len == HEADER_BYTES) ? PH_STRINGS : PH_FORMATTED;
					end
				end
			end
			PH_FORMATTED: begin
				if (pos_inc_x >= hlen_x) begin
					phase_d = PH_STRINGS;
				end
			end
			PH_STRINGS: begin
				if (pos_x == hlen_x) begin
					present_d = !nul;
					ns_cur    = 1'b0;
					nsseen_d  = 1'b0;
				end
				if ((pos_x > hlen_x) && prev_nul && nul) begin
					res_valid = 1'b1;
					kind      = KIND_DONE;
					total     = 16'(pos_inc_x);
					count     = 16'(seen);
					phase_d   = PH_IDLE;
				end else if (pos_inc_x >= lim_x) begin
					res_valid = 1'b1;
					err       = ERR_TRUNCATED;
					phase_d   = PH_IDLE;
				end else begin
					if (nul) begin
						if (present_d) begin
							tlen_w    = ns_cur ? ({1'b0, last} - {1'b0, first} + (W+1)'(1))
								: '0;
							res_valid = 1'b1;
							kind      = KIND_STRING;
							count     = 16'(seen_inc);
							num       = 16'(seen_inc);
							toff      = ns_cur ? 16'(first) : 16'(pos);
							tlen      = 16'(tlen_w);
							seen_d    = seen_inc;
							nsseen_d  = 1'b0;
						end
					end else if (!is_blank(b)) begin
						if (!ns_cur) begin
							first_d = pos;
						end
						last_d   = pos;
						nsseen_d = 1'b1;
					end
					prev_nul_d = nul;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		res.record_kind      = kind;
		res.error_code       = err;
		res.struct_type      = htype_d;
		res.struct_handle    = (kind == KIND_ERROR) && (pos == W'(0)) ? 16'd0 : handle_d;
		res.formatted_length = hlen_d;
		res.struct_size      = total;
		res.string_tally     = count;
		res.string_number    = num;
		res.trim_offset      = toff;
		res.trim_length      = tlen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			pos_q      <= '0;
			limit_q    <= '0;
			htype_q    <= 8'd0;
			hlen_q     <= 8'd0;
			handle_q   <= 16'd0;
			present_q  <= 1'b0;
			prev_nul_q <= 1'b0;
			seen_q     <= '0;
			first_q    <= '0;
			last_q     <= '0;
			nsseen_q   <= 1'b0;
		end else if (step_en) begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			limit_q    <= limit_d;
			htype_q    <= htype_d;
			hlen_q     <= hlen_d;
			handle_q   <= handle_d;
			present_q  <= present_d;
			prev_nul_q <= prev_nul_d;
			seen_q     <= seen_d;
			first_q    <= first_d;
			last_q     <= last_d;
			nsseen_q   <= nsseen_d;
		end
	end

endmodule

@@ sim/smbios_structure_parser_check.sv @@
module smbios_structure_parser_check (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_ready,
	input  smbp_pkg::item_t   item,
	input  logic              result_valid,
	input  logic              result_ready,
	input  smbp_pkg::result_t result,
	output int                failures,
	output int                outstanding,
	output int                strings_checked,
	output int                structs_done,
	output int                structs_failed
);
	import smbp_pkg::*;

	// Parser state as the block should hold it.
	phase_t      phase;
	logic [15:0] pos;
	logic [15:0] limit;
	logic [7:0]  s_type;
	logic [7:0]  s_len;
	logic [15:0] s_handle;
	logic        present;
	logic        prev_nul;
	logic [15:0] seen;
	logic [15:0] first_ns;
	logic [15:0] last_ns;
	logic        ns_seen;

	result_t records_due[$];
	result_t want;
	int      due_size = 0;
	int      fail_total = 0;
	int      n_strings = 0;
	int      n_done = 0;
	int      n_errors = 0;

	assign failures        = fail_total;
	assign outstanding     = due_size;
	assign strings_checked = n_strings;
	assign structs_done    = n_done;
	assign structs_failed  = n_errors;

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		fail_total++;
	endtask

	task automatic compare_field(input string name, input int got, input int exp_val);
		if (got != exp_val) begin
			report($sformatf("%s is %0d, expected %0d", name, got, exp_val));
		end
	endtask

	function automatic logic whitespace(input logic [7:0] b);
		logic [7:0] d;
		d = b - 8'd9;
		return (b == 8'd32) || (d < 8'd5);
	endfunction

	task automatic clear_state();
		phase    = PH_IDLE;
		pos      = '0;
		limit    = '0;
		s_type   = '0;
		s_len    = '0;
		s_handle = '0;
		present  = 1'b0;
		prev_nul = 1'b0;
		seen     = '0;
		first_ns = '0;
		last_ns  = '0;
		ns_seen  = 1'b0;
	endtask

	task automatic emit(input logic [1:0] kind, input logic [1:0] code,
		input logic [15:0] total, input logic [15:0] count, input logic [15:0] num,
		input logic [15:0] toff, input logic [15:0] tlen);
		result_t r;
		r.record_kind      = kind;
		r.error_code       = code;
		r.struct_type      = s_type;
		r.struct_handle    = s_handle;
		r.formatted_length = s_len;
		r.struct_size      = total;
		r.string_tally     = count;
		r.string_number    = num;
		r.trim_offset      = toff;
		r.trim_length      = tlen;
		records_due.push_back(r);
	endtask

	// Advances the parser by one byte and queues the record it causes, if any.
	task automatic parse_byte(input item_t it);
		logic [7:0]  b;
		logic [15:0] p;
		logic        nul;
		b = it.data_byte;
		if (it.start_flag) begin
			clear_state();
			phase = PH_HEADER;
			limit = it.bytes_available;
		end
		if (phase == PH_IDLE) return;
		p = pos;
		pos = p + 16'd1;
		case (phase)
		PH_HEADER: begin
			if (p == 16'd0) begin
				s_type = b;
				if (limit < 16'(HEADER_BYTES + STRING_SET_MIN)) begin
					emit(KIND_ERROR, ERR_TRUNCATED, '0, '0, '0, '0, '0);
					phase = PH_IDLE;
				end
			end else if (p == 16'd1) begin
				s_len = b;
			end else if (p == 16'd2) begin
				s_handle = {8'd0, b};
			end else begin
				s_handle[15:8] = b;
				if (s_len == 8'd0) begin
					s_type = END_OF_TABLE_TYPE;
					s_len  = HEADER_BYTES;
				end
				if (s_len < HEADER_BYTES) begin
					emit(KIND_ERROR, ERR_BAD_LENGTH, '0, '0, '0, '0, '0);
					phase = PH_IDLE;
				end else if ({9'd0, s_len} + 17'(STRING_SET_MIN) > {1'b0, limit}) begin
					emit(KIND_ERROR, ERR_TRUNCATED, '0, '0, '0, '0, '0);
					phase = PH_IDLE;
				end else begin
					phase = (s_len == HEADER_BYTES) ? PH_STRINGS : PH_FORMATTED;
				end
			end
		end
		PH_FORMATTED: begin
			if ({1'b0, p} + 17'd1 >= {9'd0, s_len}) phase = PH_STRINGS;
		end
		default: begin
			nul = (b == 8'd0);
			if (p == {8'd0, s_len}) begin
				present = !nul;
				ns_seen = 1'b0;
			end
			if (p > {8'd0, s_len} && prev_nul && nul) begin
				emit(KIND_DONE, ERR_NONE, p + 16'd1, seen, '0, '0, '0);
				phase = PH_IDLE;
				return;
			end
			if ({1'b0, p} + 17'd1 >= {1'b0, limit}) begin
				emit(KIND_ERROR, ERR_TRUNCATED, '0, '0, '0, '0, '0);
				phase = PH_IDLE;
				return;
			end
			if (nul) begin
				if (present) begin
					seen = seen + 16'd1;
					if (ns_seen) begin
						emit(KIND_STRING, ERR_NONE, '0, seen, seen, first_ns,
							last_ns - first_ns + 16'd1);
					end else begin
						emit(KIND_STRING, ERR_NONE, '0, seen, seen, p, '0);
					end
					ns_seen = 1'b0;
				end
			end else if (!whitespace(b)) begin
				if (!ns_seen) first_ns = p;
				last_ns = p;
				ns_seen = 1'b1;
			end
			prev_nul = nul;
		end
		endcase
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			clear_state();
			records_due.delete();
		end else begin
			if (result_valid && result_ready) begin
				if (records_due.size() == 0) begin
					report($sformatf("record of kind %0d with nothing expected",
						result.record_kind));
				end else begin
					want = records_due.pop_front();
					compare_field("record_kind", result.record_kind, want.record_kind);
					compare_field("error_code", result.error_code, want.error_code);
					compare_field("struct_type", result.struct_type, want.struct_type);
					compare_field("struct_handle", result.struct_handle, want.struct_handle);
					compare_field("formatted_length", result.formatted_length,
						want.formatted_length);
					compare_field("struct_size", result.struct_size, want.struct_size);
					compare_field("string_tally", result.string_tally, want.string_tally);
					compare_field("string_number", result.string_number, want.string_number);
					compare_field("trim_offset", result.trim_offset, want.trim_offset);
					compare_field("trim_length", result.trim_length, want.trim_length);
					if (want.record_kind == KIND_STRING) n_strings++;
					else if (want.record_kind == KIND_DONE) n_done++;
					else n_errors++;
				end
			end
			if (item_valid && item_ready) parse_byte(item);
		end
		due_size <= records_due.size();
	end

endmodule

@@ sim/smbios_structure_parser_test.sv @@
// Top of the structure parser testbench. This module only produces traffic and
// gives the verdict; the checker beside the block watches both channels,
// predicts every record and compares.
module smbios_structure_parser_test;
	import smbp_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	// The longest hold-off of the result side, in cycles.
	localparam int LONG_HOLD   = 200;
	// Generous ceiling on the whole run; a healthy run needs far less.
	localparam int CYCLE_LIMIT = 600000;
	localparam int ITEM_TARGET = 1700;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	int failures;
	int outstanding;
	int strings_checked;
	int structs_done;
	int structs_failed;

	int   cycles = 0;
	int   items_sent = 0;
	int   structs_sent = 0;
	int   hold_requests = 0;
	logic idle_on = 1'b1;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	smbios_structure_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	smbios_structure_parser_check watch (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_ready      (item_ready),
		.item            (item),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.result          (result),
		.failures        (failures),
		.outstanding     (outstanding),
		.strings_checked (strings_checked),
		.structs_done    (structs_done),
		.structs_failed  (structs_failed)
	);

	// A stuck handshake or a lost record would otherwise hang the run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d records outstanding",
				cycles, outstanding);
			$display("status: fail");
			$finish;
		end
	end

	// Result side. Each cycle it decides one value for ready: either it is in
	// the middle of a stall, or it starts a new one, or it accepts. A hold-off
	// request from the stimulus starts one long stall, long enough for the
	// block to fill up and push back on its input.
	initial begin : receiver
		int stall;
		int holds_done;
		stall = 0;
		holds_done = 0;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				result_ready <= 1'b0;
			end else if (holds_done != hold_requests) begin
				holds_done = hold_requests;
				stall = LONG_HOLD - 1;
				result_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				stall = $urandom_range(0, 13);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Offers one byte and returns at the edge where it is transferred. Valid is
	// only lowered for an idle burst before the byte; otherwise it stays high
	// from one transfer to the next and only the payload changes.
	task automatic offer(input logic [7:0] d, input logic s, input logic [15:0] a);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{data_byte: d, start_flag: s, bytes_available: a};
		items_sent++;
		do @(posedge clk); while (!item_ready);
	endtask

	// Only the first byte carries the start mark and the byte count; on the
	// others the count is noise that the block must not look at.
	task automatic send_struct(input byte_q_t q, input logic [15:0] avail);
		foreach (q[i]) begin
			offer(q[i], i == 0, (i == 0) ? avail : 16'($urandom));
		end
		structs_sent++;
	endtask

	// Stops offering and waits until every predicted record has been taken.
	// The first edge lets the checker account for the last transfer.
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// String text leans on whitespace so that trimming gets real work.
	function automatic logic [7:0] text_char(input logic blank_only);
		int r;
		if (blank_only || $urandom_range(0, 2) == 0) begin
			r = $urandom_range(0, 5);
			return (r == 5) ? 8'd32 : 8'(9 + r);
		end
		return 8'($urandom_range(1, 255));
	endfunction

	// Builds a well-formed structure: header, formatted area of random bytes and
	// a string set with its double NUL. A negative fixed_len picks the header
	// length at random, mostly small, now and then zero or too short. With many
	// set, the structure carries a dozen tiny strings so that records come
	// nearly every other byte.
	task automatic make_struct(output byte_q_t q, input logic many, input int fixed_len);
		int r;
		int len;
		int eff;
		int nstr;
		logic blank_only;
		q = {};
		r = $urandom_range(0, 19);
		if (fixed_len >= 0) len = fixed_len;
		else if (many) len = 4;
		else if (r < 2) len = 0;
		else if (r == 2) len = $urandom_range(1, 3);
		else if (r < 17) len = $urandom_range(4, 24);
		else len = $urandom_range(25, 255);
		q.push_back(8'($urandom));
		q.push_back(8'(len));
		q.push_back(8'($urandom));
		q.push_back(8'($urandom));
		eff = (len == 0) ? 4 : len;
		for (int i = 4; i < eff; i++) q.push_back(8'($urandom));
		r = many ? 10 : $urandom_range(0, 19);
		if (r == 0) begin
			// Empty string set.
			q.push_back(8'd0);
			q.push_back(8'd0);
		end else if (r == 1) begin
			// Set opens with NUL, so whatever follows is not counted.
			q.push_back(8'd0);
			repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(1, 255)));
			q.push_back(8'd0);
			q.push_back(8'd0);
		end else begin
			nstr = many ? 12 : $urandom_range(1, 5);
			repeat (nstr) begin
				blank_only = ($urandom_range(0, 7) == 0);
				repeat (many ? $urandom_range(1, 2) : $urandom_range(1, 8)) begin
					q.push_back(text_char(blank_only));
				end
				q.push_back(8'd0);
			end
			q.push_back(8'd0);
		end
	endtask

	// Byte count for a structure of the given size: mostly enough, sometimes
	// exact, sometimes short so that every truncation point is reached.
	function automatic logic [15:0] pick_avail(input int total);
		case ($urandom_range(0, 9))
		0: return 16'(total);
		1: return 16'hFFFF;
		2: return 16'($urandom);
		3: return 16'($urandom_range(0, total - 1));
		4: return 16'($urandom_range(total, 65535));
		default: return 16'(total + $urandom_range(0, 20));
		endcase
	endfunction

	// Random structures until the byte count reaches the given mark. A few get
	// idle bytes in front of them, and a few are cut short and abandoned by the
	// start of the next one.
	task automatic random_structs(input int until_items);
		byte_q_t q;
		logic [15:0] avail;
		int r;
		int cut;
		while (items_sent < until_items) begin
			make_struct(q, 1'b0, -1);
			avail = pick_avail(q.size());
			r = $urandom_range(0, 19);
			if (r == 0) begin
				repeat ($urandom_range(1, 3)) offer(8'($urandom), 1'b0, 16'($urandom));
			end else if (r == 1) begin
				cut = $urandom_range(1, q.size() - 1);
				q = q[0:cut - 1];
			end
			send_struct(q, avail);
		end
	endtask

	initial begin : stimulus
		byte_q_t q;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bytes before any structure are ignored.
		offer(8'hAA, 1'b0, 16'hFFFF);
		// Too few bytes available: rejected on the type byte, twice.
		send_struct('{8'hFF}, 16'd5);
		send_struct('{8'h00}, 16'd0);
		// Bytes after an error record are ignored as well.
		offer(8'h55, 1'b0, 16'h0000);
		// Zero header length: end-of-table with a 4-byte formatted area.
		send_struct('{8'h12, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00}, 16'd6);
		// Header lengths below four are invalid.
		send_struct('{8'h01, 8'h03, 8'h34, 8'h12}, 16'd100);
		send_struct('{8'h02, 8'h01, 8'h00, 8'h00}, 16'hFFFF);
		// Header length that leaves no room for the string set.
		send_struct('{8'h04, 8'h0A, 8'h01, 8'h00}, 16'd11);
		// Set opening with NUL and junk after it: no strings counted.
		send_struct('{8'h20, 8'h05, 8'h00, 8'h80, 8'h55, 8'h00, 8'h41, 8'h00, 8'h00},
			16'd9);
		// A whitespace-only string, then a padded one.
		send_struct('{8'h03, 8'h04, 8'h01, 8'h00, 8'h20, 8'h09, 8'h00,
			8'h0D, 8'h58, 8'h20, 8'h00, 8'h00}, 16'd12);
		// Missing terminator, once mid-string and once on a string's NUL.
		send_struct('{8'h05, 8'h04, 8'h02, 8'h00, 8'h41, 8'h42, 8'h00, 8'h43}, 16'd8);
		send_struct('{8'h06, 8'h04, 8'h03, 8'h00, 8'h41, 8'h00}, 16'd6);
		// Restart in the middle of a header abandons it silently.
		send_struct('{8'h07, 8'h10, 8'h01}, 16'd40);
		send_struct('{8'h08, 8'h04, 8'h11, 8'h22, 8'h00, 8'h00}, 16'd6);
		// Largest header length.
		make_struct(q, 1'b0, 255);
		send_struct(q, 16'hFFFF);
		drain();

		// Long hold-off on the result side while string-heavy structures keep
		// coming, so the block must stall its input.
		hold_requests <= hold_requests + 1;
		repeat (3) begin
			make_struct(q, 1'b1, -1);
			send_struct(q, 16'(q.size() + $urandom_range(0, 4)));
		end
		drain();

		random_structs(700);
		drain();
		idle_on <= 1'b0;
		random_structs(1000);
		drain();
		idle_on <= 1'b1;
		random_structs(1400);
		drain();
		// Closing stretch at full rate on both sides.
		idle_on <= 1'b0;
		random_structs(ITEM_TARGET);
		drain();
		repeat (16) @(posedge clk);

		$display("run covered %0d bytes in %0d structures,", items_sent, structs_sent);
		$display("with idle bursts and a %0d-cycle hold-off; records checked: %0d strings,",
			LONG_HOLD, strings_checked);
		$display("%0d structures done, %0d errors", structs_done, structs_failed);
		if (failures == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", failures);
			$display("status: fail");
		end
		$finish;
	end

endmodule
